FILE: design/table_linear_interpolation_assert.svh
// Assertion macros for the table interpolation block.
// Used by the top level only; needs clock and reset in scope.
`ifndef TABLE_LINEAR_INTERPOLATION_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATION_ASSERT_SVH
`define TLI_ASSERT_IMP(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("assertion failed");
`define TLI_ASSERT_NXT(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("assertion failed");
`endif

FILE: design/tli_pkg.sv
// Package for the table interpolation block: widths and opcodes.
// No dependencies.
package tli_pkg;
   localparam int ENTRIES_DEF = 256;
   localparam int STOKES_DEF  = 4;
   localparam int CNT_W  = 9;
   localparam int ANG_W  = 24;
   localparam int VAL_W  = 32;
   localparam int IDX_W  = 8;
   localparam int RC_W   = 2;
   localparam int OP_W   = 2;
   localparam logic [OP_W-1:0] OP_WR_ANGLE = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_ELEM  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
endpackage

FILE: design/table_linear_interpolation.sv
// Table interpolation block: binary search over an angle memory, serial ratio
// divider and a blend against an element memory.
// Usage:
//  Requests enter on req_valid/req_ready. Opcode 0 stores an angle, 1 stores a
//  matrix element, 2 queries one interpolated element; 3 is dropped. Writes
//  give no response.
//  A query gives one response on rsp_valid/rsp_ready. When a blend is needed
//  it runs the binary search reads, the serial divider, two element reads,
//  a multiply and a saturate; edge and exact-match cases skip the divider.
//  A stalled receiver holds the response unchanged.
//  One request is handled at a time; the response register lets the next
//  request be taken while a response waits, but a further query waits until
//  that response is taken.
//  csr_we writes entry_count (saturated to ENTRIES); the user must write it
//  only while idle; the block does not enforce this. Reset clears control
//  state and the count; table contents stay undefined until written.
// Depends on tli_pkg, tli_divider, tli_tables and the assertion header.
`include "table_linear_interpolation_assert.svh"
module table_linear_interpolation #(
   parameter int ENTRIES = tli_pkg::ENTRIES_DEF,
   parameter int STOKES  = tli_pkg::STOKES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [tli_pkg::OP_W-1:0]  req_opcode,
   input  logic [tli_pkg::IDX_W-1:0] req_entry_index,
   input  logic [tli_pkg::RC_W-1:0]  req_element_row,
   input  logic [tli_pkg::RC_W-1:0]  req_element_col,
   input  logic [tli_pkg::ANG_W-1:0] req_angle_value,
   input  logic signed [tli_pkg::VAL_W-1:0] req_element_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [tli_pkg::VAL_W-1:0] rsp_interpolated_value,
   input  logic                      csr_we,
   input  logic [tli_pkg::CNT_W-1:0] csr_wdata
);
   import tli_pkg::*;
   localparam int EW = $clog2(ENTRIES);
   localparam int SW = (STOKES > 1) ? $clog2(STOKES) : 1;
   localparam int NW = EW + 1;

   localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_CHK0 = 4'd2,
      S_RDL = 4'd3, S_CHKL = 4'd4, S_SRD = 4'd5, S_SCMP = 4'd6, S_ARD = 4'd7,
      S_ACHK = 4'd8, S_DIV = 4'd9, S_VP = 4'd10, S_VN = 4'd11, S_MUL = 4'd12,
      S_SUM = 4'd13, S_ONE = 4'd14, S_ONE2 = 4'd15;

   logic [3:0]       st_ff, st_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic [NW-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [ANG_W-1:0] q_ff, q_in, an_ff, an_in;
   logic [SW-1:0]    row_ff, row_in, col_ff, col_in;
   logic [VAL_W-1:0] vp_ff, vp_in;
   logic [15:0]      r_ff, r_in;
   logic signed [48:0] prod_ff, prod_in;
   logic             ov_ff, ov_in;
   logic signed [VAL_W-1:0] out_ff, out_in;

   logic [EW-1:0]    ang_raddr, el_ridx;
   logic [ANG_W-1:0] ang_rdata;
   logic [VAL_W-1:0] el_rdata;
   logic             div_start, div_done;
   logic [15:0]      div_q;
   logic [ANG_W-1:0] div_num, div_den;
   logic [NW-1:0]    mid, nm1;
   logic             rc_ok, idx_ok, take;
   logic signed [33:0] diff;
   logic signed [49:0] sum;
   logic             ang_we, el_we;
   logic             div_busy_ff, div_busy_in, div_busy_wait;

   assign take = req_valid && req_ready;
   assign req_ready = (st_ff == S_IDLE) && !(ov_ff && req_opcode == OP_QUERY);
   assign rsp_valid = ov_ff;
   assign rsp_interpolated_value = out_ff;
   assign nm1 = cnt_ff - NW'(1);
   assign mid = NW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign rc_ok = (32'(req_element_row) < STOKES) && (32'(req_element_col) < STOKES);
   assign idx_ok = 32'(req_entry_index) < ENTRIES;
   assign ang_we = take && req_opcode == OP_WR_ANGLE && idx_ok;
   assign el_we  = take && req_opcode == OP_WR_ELEM && idx_ok && rc_ok;
   assign diff = 34'(signed'(el_rdata)) - 34'(signed'(vp_ff));
   assign sum = 50'(signed'(vp_ff)) + 50'(prod_ff >>> 16);
   assign div_num = q_ff - an_ff;
   assign div_den = ang_rdata - an_ff;

   always_comb begin
      ang_raddr = '0;
      el_ridx = lo_ff[EW-1:0];
      case (st_ff)
         S_RD0:  ang_raddr = '0;
         S_RDL:  ang_raddr = nm1[EW-1:0];
         S_SRD:  ang_raddr = mid[EW-1:0];
         S_ARD:  ang_raddr = lo_ff[EW-1:0] - EW'(1);
         S_ACHK: ang_raddr = lo_ff[EW-1:0];
         S_DIV:  ang_raddr = lo_ff[EW-1:0];
         S_VP:   el_ridx = lo_ff[EW-1:0] - EW'(1);
         default: ;
      endcase
   end

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; lo_in = lo_ff; hi_in = hi_ff; q_in = q_ff;
      an_in = an_ff; row_in = row_ff; col_in = col_ff; vp_in = vp_ff; r_in = r_ff;
      prod_in = prod_ff; ov_in = ov_ff; out_in = out_ff; div_start = 1'b0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      if (csr_we) cnt_in = (32'(csr_wdata) > ENTRIES) ? NW'(ENTRIES) : NW'(csr_wdata);
      case (st_ff)
         S_IDLE: begin
            if (take && req_opcode == OP_QUERY) begin
               q_in = req_angle_value;
               row_in = SW'(req_element_row); col_in = SW'(req_element_col);
               if (cnt_ff == '0 || !rc_ok) begin
                  out_in = '0; ov_in = 1'b1;
               end else begin
                  st_in = S_RD0;
               end
            end
         end
         S_RD0: st_in = S_CHK0;
         S_CHK0: begin
            lo_in = '0;
            st_in = (q_ff <= ang_rdata) ? S_ONE : S_RDL;
         end
         S_RDL: st_in = S_CHKL;
         S_CHKL: begin
            if (q_ff >= ang_rdata) begin
               lo_in = nm1; st_in = S_ONE;
            end else begin
               lo_in = '0; hi_in = cnt_ff; st_in = S_SRD;
            end
         end
         S_SRD: st_in = (lo_ff < hi_ff) ? S_SCMP : S_ARD;
         S_SCMP: begin
            if (ang_rdata < q_ff) lo_in = mid + NW'(1);
            else hi_in = mid;
            st_in = S_SRD;
         end
         S_ARD: begin
            if (lo_ff < NW'(1)) lo_in = NW'(1);
            else if (lo_ff > nm1) lo_in = nm1;
            st_in = S_ACHK;
         end
         S_ACHK: begin
            an_in = ang_rdata;
            st_in = S_DIV;
         end
         S_DIV: begin
            if (ang_rdata == q_ff) begin
               st_in = S_ONE;
            end else if (ang_rdata <= an_ff || q_ff <= an_ff) begin
               r_in = '0; st_in = S_VP;
            end else begin
               div_start = 1'b1; st_in = S_VP;
            end
         end
         S_VP: begin
            if (div_done) r_in = div_q;
            st_in = S_VN;
         end
         S_VN: begin
            vp_in = el_rdata;
            st_in = S_MUL;
         end
         S_MUL: begin
            if (div_done) r_in = div_q;
            prod_in = 49'($signed({1'b0, r_ff})) * 49'(diff);
            st_in = S_SUM;
         end
         S_SUM: begin
            if (sum > 50'sd2147483647) out_in = 32'h7fffffff;
            else if (sum < -50'sd2147483648) out_in = 32'h80000000;
            else out_in = VAL_W'(sum);
            ov_in = 1'b1; st_in = S_IDLE;
         end
         S_ONE: st_in = S_ONE2;
         S_ONE2: begin
            out_in = el_rdata; ov_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      if (st_ff == S_VP && div_busy_wait) st_in = S_VP;
   end

   // hold in S_VP, reading the lower neighbour, until the ratio is known
   assign div_busy_in = div_start ? 1'b1 : (div_done ? 1'b0 : div_busy_ff);
   assign div_busy_wait = div_busy_ff && !div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; ov_ff <= 1'b0; div_busy_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; ov_ff <= ov_in; div_busy_ff <= div_busy_in;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; q_ff <= q_in; an_ff <= an_in; row_ff <= row_in;
      col_ff <= col_in; vp_ff <= vp_in; prod_ff <= prod_in; out_ff <= out_in;
      r_ff <= (div_busy_ff && div_done) ? div_q : r_in;
   end

   tli_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quot(div_q)
   );

   tli_tables #(.ENTRIES(ENTRIES), .STOKES(STOKES), .EW(EW), .SW(SW)) u_tab (
      .clock(clock),
      .ang_we(ang_we), .ang_waddr(req_entry_index[EW-1:0]), .ang_wdata(req_angle_value),
      .ang_raddr(ang_raddr), .ang_rdata(ang_rdata),
      .el_we(el_we),
      .el_waddr({req_entry_index[EW-1:0], req_element_row[SW-1:0],
                 req_element_col[SW-1:0]}),
      .el_wdata(req_element_value),
      .el_raddr({el_ridx, row_ff, col_ff}), .el_rdata(el_rdata)
   );

   `TLI_ASSERT_IMP(a_busy_no_ready, st_ff != S_IDLE, !req_ready)
   `TLI_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_interpolated_value))
   `TLI_ASSERT_IMP(a_cnt_range, 1'b1, 32'(cnt_ff) <= ENTRIES)
endmodule

FILE: design/tli_divider.sv
// Restoring serial divider: quotient = (num << 16) / den, 16 bits, one bit a cycle.
// Depends on tli_pkg.
module tli_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tli_pkg::ANG_W-1:0] num,
   input  logic [tli_pkg::ANG_W-1:0] den,
   output logic                      done,
   output logic [15:0]               quot
);
   import tli_pkg::*;
   logic [ANG_W:0]  rem_ff, rem_in;
   logic [ANG_W-1:0] den_ff, den_in;
   logic [15:0]      q_ff, q_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [ANG_W+1:0] trial;

   assign quot = q_ff;
   assign done = busy_ff && (cnt_ff == 5'd0);
   assign trial = {rem_ff, 1'b0} - {2'b00, den_ff};

   always_comb begin
      rem_in = rem_ff; den_in = den_ff; q_in = q_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         rem_in = {1'b0, num}; den_in = den; q_in = '0; cnt_in = 5'd16; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
         end else begin
            if (!trial[ANG_W+1]) begin
               rem_in = trial[ANG_W:0];
               q_in = {q_ff[14:0], 1'b1};
            end else begin
               rem_in = {rem_ff[ANG_W-1:0], 1'b0};
               q_in = {q_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; den_ff <= den_in; q_ff <= q_in;
   end
endmodule

FILE: design/tli_tables.sv
// Angle and element memories, synchronous read: read data is registered and appears in the cycle after the address.
// Depends on tli_pkg.
module tli_tables #(
   parameter int ENTRIES = tli_pkg::ENTRIES_DEF,
   parameter int STOKES  = tli_pkg::STOKES_DEF,
   parameter int EW = $clog2(ENTRIES),
   parameter int SW = (STOKES > 1) ? $clog2(STOKES) : 1
) (
   input  logic                      clock,
   input  logic                      ang_we,
   input  logic [EW-1:0]             ang_waddr,
   input  logic [tli_pkg::ANG_W-1:0] ang_wdata,
   input  logic [EW-1:0]             ang_raddr,
   output logic [tli_pkg::ANG_W-1:0] ang_rdata,
   input  logic                      el_we,
   input  logic [EW+2*SW-1:0]        el_waddr,
   input  logic [tli_pkg::VAL_W-1:0] el_wdata,
   input  logic [EW+2*SW-1:0]        el_raddr,
   output logic [tli_pkg::VAL_W-1:0] el_rdata
);
   import tli_pkg::*;
   logic [ANG_W-1:0] ang_mem [ENTRIES];
   logic [VAL_W-1:0] el_mem  [ENTRIES << (2*SW)];

   always_ff @(posedge clock) begin
      if (ang_we) begin
         ang_mem[ang_waddr] <= ang_wdata;
      end
      ang_rdata <= ang_mem[ang_raddr];
   end

   always_ff @(posedge clock) begin
      if (el_we) begin
         el_mem[el_waddr] <= el_wdata;
      end
      el_rdata <= el_mem[el_raddr];
   end
endmodule
